>>> src/scatter_direction_rotate_unit_macros.svh
// Assertion macros for the scatter direction rotate unit.
`ifndef SCATTER_DIRECTION_ROTATE_UNIT_MACROS_SVH
`define SCATTER_DIRECTION_ROTATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SDR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDR_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SDR_ASSERT(label, clk, rst, prop, msg)
`define SDR_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> src/sdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants
// Command codes, the CORDIC arctangent table, controller commands and status.
// ----------------------------------------------------------------------------
package sdr_pkg;

  localparam int AngleBitsDefault = 24;
  localparam int CordicStepsDefault = 24;
  localparam int TableLen = 32;

  localparam logic signed [63:0] InvGainQ30 = 64'sd652032874;
  localparam logic [63:0] HalfTurn = 64'h8000_0000_0000_0000;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_KICK = 1'b1
  } command_t;

  // atan(2^-i) in turn units, full turn = 2^64
  function automatic logic [63:0] atan_entry(input logic [4:0] i);
    logic [63:0] r;
    unique case (i)
      5'd0:  r = 64'h2000000000000000;
      5'd1:  r = 64'h12E4051D9DF30800;
      5'd2:  r = 64'h09FB385B5EE39E80;
      5'd3:  r = 64'h051111D41DDD9A40;
      5'd4:  r = 64'h028B0D430E589B00;
      5'd5:  r = 64'h0145D7E159046278;
      5'd6:  r = 64'h00A2F61E5C282630;
      5'd7:  r = 64'h00517C5511D442B0;
      5'd8:  r = 64'h0028BE5346D0C338;
      5'd9:  r = 64'h00145F2EBB30AB38;
      5'd10: r = 64'h000A2F980091BA7B;
      5'd11: r = 64'h000517CC14A80CB7;
      5'd12: r = 64'h00028BE60CDFEC62;
      5'd13: r = 64'h000145F306C172F1;
      5'd14: r = 64'h0000A2F9836AE913;
      5'd15: r = 64'h0000517CC1B6BA7C;
      5'd16: r = 64'h000028BE60DB85FB;
      5'd17: r = 64'h0000145F306DC81A;
      5'd18: r = 64'h00000A2F9836E4B1;
      5'd19: r = 64'h00000517CC1B726C;
      5'd20: r = 64'h0000028BE60DB938;
      5'd21: r = 64'h00000145F306DC9C;
      5'd22: r = 64'h000000A2F9836E4E;
      5'd23: r = 64'h000000517CC1B727;
      5'd24: r = 64'h00000028BE60DB93;
      5'd25: r = 64'h000000145F306DC9;
      5'd26: r = 64'h0000000A2F9836E4;
      5'd27: r = 64'h0000000517CC1B72;
      5'd28: r = 64'h000000028BE60DB9;
      5'd29: r = 64'h0000000145F306DC;
      5'd30: r = 64'h00000000A2F9836E;
      default: r = 64'h00000000517CC1B7;
    endcase
    return r;
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_ROT,
    ST_VEC,
    ST_MUL,
    ST_DONE
  } state_t;

  // one step of the kick program per sequencer slot
  typedef enum logic [4:0] {
    OP_SC_POL, OP_SC_AZ, OP_SC_KP, OP_SC_KA,
    OP_M_D0, OP_M_D1, OP_M_CT_CP, OP_M_ST_CP, OP_M_SP_CT, OP_M_ST_SP,
    OP_M_X0, OP_M_X1, OP_M_X2, OP_M_Y0, OP_M_Y1, OP_M_Y2, OP_M_Z0, OP_M_Z1,
    OP_VEC_AZ, OP_M_RHO, OP_VEC_POL, OP_FINISH
  } op_t;

  typedef struct packed {
    logic start_load;  // capture loaded angles
    logic start_kick;  // latch kick angles
    logic op_start;    // begin the current op
    op_t  op;
    logic finish;      // commit angles
  } sdr_cmd_t;

  typedef struct packed {
    logic op_done;
  } sdr_status_t;

endpackage
`default_nettype wire

>>> src/sdr_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_stream_if: valid/ready channel
// Carries a payload of a given type between a source and a sink.
// ----------------------------------------------------------------------------
interface sdr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/sdr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_ctrl: sequencer
// Walks the kick program one op at a time and runs the handshakes.
// ----------------------------------------------------------------------------
module sdr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_command,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output sdr_pkg::sdr_cmd_t         cmd,
  input  wire sdr_pkg::sdr_status_t status
);
  import sdr_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;
  logic   launched, launched_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      op        <= OP_SC_POL;
      launched  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      launched  <= launched_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next     = state;
    op_next        = op;
    launched_next  = launched;
    out_valid_next = out_valid;
    if (out_valid && out_ready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !out_valid) begin
          if (in_command == CMD_LOAD) begin
            out_valid_next = 1'b1;
          end else begin
            state_next    = ST_TRIG;
            op_next       = OP_SC_POL;
            launched_next = 1'b0;
          end
        end
      end
      ST_TRIG, ST_ROT, ST_VEC, ST_MUL: begin
        if (!launched) begin
          launched_next = 1'b1;
        end else if (status.op_done) begin
          launched_next = 1'b0;
          op_next       = op_t'(op + 5'd1);
          if (op == OP_VEC_POL) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        state_next     = ST_IDLE;
        out_valid_next = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready         = (state == ST_IDLE) && !out_valid;
    cmd.start_load   = in_ready && in_valid && (in_command == CMD_LOAD);
    cmd.start_kick   = in_ready && in_valid && (in_command == CMD_KICK);
    cmd.op_start     = (state != ST_IDLE) && (state != ST_DONE) && !launched;
    cmd.op           = op;
    cmd.finish       = (state == ST_DONE);
  end

endmodule
`default_nettype wire

>>> src/sdr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdr_datapath: shared CORDIC, multiplier and register file
// One CORDIC iteration per cycle; one Q30 product at a time, one per multiply op.
// ----------------------------------------------------------------------------
module sdr_datapath #(
  parameter int ANGLE_BITS   = sdr_pkg::AngleBitsDefault,
  parameter int CORDIC_STEPS = sdr_pkg::CordicStepsDefault
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sdr_pkg::sdr_cmd_t             cmd,
  output sdr_pkg::sdr_status_t               status,
  input  wire logic [ANGLE_BITS-2:0]         load_polar,
  input  wire logic signed [ANGLE_BITS-1:0]  load_azimuth,
  input  wire logic signed [ANGLE_BITS-1:0]  kick_polar,
  input  wire logic signed [ANGLE_BITS-1:0]  kick_azimuth,
  output logic [ANGLE_BITS-2:0]              new_polar,
  output logic signed [ANGLE_BITS-1:0]       new_azimuth
);
  import sdr_pkg::*;

  localparam int Sh = 64 - ANGLE_BITS;
  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  logic [ANGLE_BITS-1:0] dir_pol, dir_az, kp, ka;
  logic signed [63:0] ct, st, cp, sp, ct0, st0, cp0, sp0;
  logic signed [63:0] d0, d1, t_ctcp, t_stcp, t_spct, t_stsp, acc_x, acc_y, acc_z, rho;
  logic [63:0] az_ang;

  // CORDIC core
  logic signed [63:0] cx, cy;
  logic [63:0]        ca;
  logic               vec_mode, flip, busy, mul_busy;
  logic [StepW-1:0]   step;
  logic [4:0]         tidx;
  logic signed [63:0] mul_a, mul_b, mul_p;
  logic signed [63:0] dx, dy;
  logic [63:0]        atan_v, sc_ang;
  logic signed [63:0] vx, vy;
  logic               cdone;

  assign tidx   = 5'(step);
  assign atan_v = atan_entry(tidx);
  assign dx     = cy >>> tidx;
  assign dy     = cx >>> tidx;

  function automatic logic [63:0] top_ang(input logic [ANGLE_BITS-1:0] a);
    return {a, {Sh{1'b0}}};
  endfunction

  always_comb begin
    sc_ang = '0;
    vx     = '0;
    vy     = '0;
    case (cmd.op)
      OP_SC_POL: sc_ang = top_ang(dir_pol);
      OP_SC_AZ:  sc_ang = top_ang(dir_az);
      OP_SC_KP:  sc_ang = top_ang(kp);
      OP_SC_KA:  sc_ang = top_ang(ka);
      OP_VEC_AZ: begin vx = acc_x; vy = acc_y; end
      default:   begin vx = acc_z; vy = rho; end
    endcase
  end

  assign cdone = busy && (step == StepW'(CORDIC_STEPS));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.op_start && (cmd.op == OP_SC_POL || cmd.op == OP_SC_AZ ||
                 cmd.op == OP_SC_KP || cmd.op == OP_SC_KA)) begin
      busy     <= 1'b1;
      vec_mode <= 1'b0;
      step     <= '0;
      flip     <= sc_ang[63] ^ sc_ang[62];
      ca       <= (sc_ang[63] ^ sc_ang[62]) ? sc_ang + HalfTurn : sc_ang;
      cx       <= InvGainQ30;
      cy       <= '0;
    end else if (cmd.op_start && (cmd.op == OP_VEC_AZ || cmd.op == OP_VEC_POL)) begin
      busy     <= 1'b1;
      vec_mode <= 1'b1;
      flip     <= 1'b0;
      if (vx == 0 && vy == 0) begin
        step <= StepW'(CORDIC_STEPS);
        cx   <= '0;
        cy   <= '0;
        ca   <= '0;
      end else begin
        step <= '0;
        cx   <= vx[63] ? -vx : vx;
        cy   <= vx[63] ? -vy : vy;
        ca   <= vx[63] ? HalfTurn : '0;
      end
    end else if (cdone) begin
      busy <= 1'b0;
    end else if (busy) begin
      step <= step + StepW'(1);
      if (vec_mode ? !cy[63] : ca[63]) begin
        cx <= cx + dx;
        cy <= cy - dy;
        ca <= vec_mode ? ca + atan_v : ca + atan_v;
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        ca <= ca - atan_v;
      end
    end
  end

  // Q30 product, one per op
  function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b + 64'sd536870912;
    return p >>> 30;
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_M_D0:    begin mul_a = st0;    mul_b = cp0; end
      OP_M_D1:    begin mul_a = st0;    mul_b = sp0; end
      OP_M_CT_CP: begin mul_a = cp;     mul_b = ct;  end
      OP_M_ST_CP: begin mul_a = st;     mul_b = cp;  end
      OP_M_SP_CT: begin mul_a = sp;     mul_b = ct;  end
      OP_M_ST_SP: begin mul_a = st;     mul_b = sp;  end
      OP_M_X0:    begin mul_a = sp;     mul_b = d0;  end
      OP_M_X1:    begin mul_a = t_ctcp; mul_b = d1;  end
      OP_M_X2:    begin mul_a = t_stcp; mul_b = ct0; end
      OP_M_Y0:    begin mul_a = cp;     mul_b = d0;  end
      OP_M_Y1:    begin mul_a = t_spct; mul_b = d1;  end
      OP_M_Y2:    begin mul_a = t_stsp; mul_b = ct0; end
      OP_M_Z0:    begin mul_a = st;     mul_b = d1;  end
      OP_M_Z1:    begin mul_a = ct;     mul_b = ct0; end
      default:    begin mul_a = cx;     mul_b = InvGainQ30; end
    endcase
  end

  // operands stay in Q30 range, so 32x32 bits suffice
  assign mul_p = mulq(64'(signed'(mul_a[31:0])), 64'(signed'(mul_b[31:0])));

  logic is_mul;
  assign is_mul = cmd.op inside {OP_M_D0, OP_M_D1, OP_M_CT_CP, OP_M_ST_CP,
      OP_M_SP_CT, OP_M_ST_SP, OP_M_X0, OP_M_X1, OP_M_X2, OP_M_Y0, OP_M_Y1,
      OP_M_Y2, OP_M_Z0, OP_M_Z1, OP_M_RHO};

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
    end else begin
      mul_busy <= cmd.op_start && is_mul;
    end
  end

  // results land in the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      dir_pol <= '0;
      dir_az  <= '0;
    end else if (cmd.start_load) begin
      dir_pol <= {1'b0, load_polar};
      dir_az  <= load_azimuth;
    end else if (cmd.finish) begin
      dir_az  <= round_ang(az_ang);
      dir_pol <= pol_clamp(ca);
    end
    if (cmd.start_kick) begin
      kp <= kick_polar;
      ka <= kick_azimuth;
    end
    if (cdone && !vec_mode) begin
      case (cmd.op)
        OP_SC_POL: begin ct  <= flip ? -cx : cx; st  <= flip ? -cy : cy; end
        OP_SC_AZ:  begin cp  <= flip ? -cx : cx; sp  <= flip ? -cy : cy; end
        OP_SC_KP:  begin ct0 <= flip ? -cx : cx; st0 <= flip ? -cy : cy; end
        default:   begin cp0 <= flip ? -cx : cx; sp0 <= flip ? -cy : cy; end
      endcase
    end
    if (cdone && vec_mode && cmd.op == OP_VEC_AZ) begin
      az_ang <= ca;
    end
    if (mul_busy) begin
      case (cmd.op)
        OP_M_D0:    d0     <= mul_p;
        OP_M_D1:    d1     <= mul_p;
        OP_M_CT_CP: t_ctcp <= mul_p;
        OP_M_ST_CP: t_stcp <= mul_p;
        OP_M_SP_CT: t_spct <= mul_p;
        OP_M_ST_SP: t_stsp <= mul_p;
        OP_M_X0:    acc_x  <= -mul_p;
        OP_M_X1:    acc_x  <= acc_x - mul_p;
        OP_M_X2:    acc_x  <= acc_x + mul_p;
        OP_M_Y0:    acc_y  <= mul_p;
        OP_M_Y1:    acc_y  <= acc_y - mul_p;
        OP_M_Y2:    acc_y  <= acc_y + mul_p;
        OP_M_Z0:    acc_z  <= mul_p;
        OP_M_Z1:    acc_z  <= acc_z + mul_p;
        default:    rho    <= mul_p;
      endcase
    end
  end

  function automatic logic [ANGLE_BITS-1:0] round_ang(input logic [63:0] u);
    logic [63:0] r;
    r = u + (64'd1 << (Sh - 1));
    return r[63 -: ANGLE_BITS];
  endfunction

  function automatic logic [ANGLE_BITS-1:0] pol_clamp(input logic [63:0] u);
    logic [63:0] v;
    logic [ANGLE_BITS-1:0] r;
    v = u[63] ? (u[62] ? 64'd0 : HalfTurn) : u;
    r = round_ang(v);
    return r[ANGLE_BITS-1] ? {1'b0, {(ANGLE_BITS-1){1'b1}}} : r;
  endfunction

  assign status.op_done = cdone || mul_busy;
  assign new_polar      = dir_pol[ANGLE_BITS-2:0];
  assign new_azimuth    = dir_az;

endmodule
`default_nettype wire

>>> src/scatter_direction_rotate_unit.sv
`timescale 1ns / 1ps
`default_nettype none
`include "scatter_direction_rotate_unit_macros.svh"
// ----------------------------------------------------------------------------
// scatter_direction_rotate_unit: multiple-scattering direction update
// Holds a direction as polar angle and azimuth; loads it or kicks it.
// ----------------------------------------------------------------------------
// Usage:
//   in  : command, load_polar, load_azimuth, kick_polar, kick_azimuth.
//   out : new_polar, new_azimuth, one transaction per input transaction.
//   A load transaction sets the direction and answers in the next cycle.
//   A kick runs four CORDIC sine/cosine passes, two vectoring passes and
//   fifteen Q30 products on one shared rotator and one multiplier, one op
//   at a time; the result turns valid once the last vectoring pass is
//   committed in the done state. The next kick is taken only after that
//   result has been accepted.
//   The shared rotator, one iteration per cycle, sets the pace of a kick.
//   One item is in flight at a time; in.ready is low while busy or while a
//   result waits. The result register holds while out.ready is low.
//   Reset clears the direction to zero and drops any pending result.
// ----------------------------------------------------------------------------
module scatter_direction_rotate_unit #(
  parameter int ANGLE_BITS   = sdr_pkg::AngleBitsDefault,
  parameter int CORDIC_STEPS = sdr_pkg::CordicStepsDefault
) (
  input wire logic clk,
  input wire logic rst,
  sdr_stream_if.sink   in,
  sdr_stream_if.source out
);
  import sdr_pkg::*;

  sdr_cmd_t    cmd;
  sdr_status_t status;

  // sequence the kick program
  sdr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in.valid),
    .in_command (in.payload.command),
    .in_ready   (in.ready),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .cmd        (cmd),
    .status     (status)
  );

  // hold the direction and do the arithmetic
  sdr_datapath #(
    .ANGLE_BITS   (ANGLE_BITS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .load_polar   (in.payload.load_polar),
    .load_azimuth (in.payload.load_azimuth),
    .kick_polar   (in.payload.kick_polar),
    .kick_azimuth (in.payload.kick_azimuth),
    .new_polar    (out.payload.new_polar),
    .new_azimuth  (out.payload.new_azimuth)
  );

  `SDR_ASSERT(a_no_accept_while_pending, clk, rst, out.valid |-> !in.ready, "accept while pending")
  `SDR_ASSERT(a_hold_result, clk, rst, (out.valid && !out.ready) |=> out.valid, "result dropped")
  `SDR_ASSERT(a_one_cmd, clk, rst, !(cmd.start_load && cmd.start_kick), "two starts")

endmodule
`default_nettype wire

>>> dv/scatter_direction_rotate_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scatter_direction_rotate_unit_test: self-checking bench for the rotate unit
// Drives load and kick transactions with random idle bursts on both channels.
// Checks every result against a fixed-point CORDIC predictor of the unit.
// ----------------------------------------------------------------------------
module scatter_direction_rotate_unit_test;
  import sdr_pkg::*;

  typedef struct packed {
    command_t           command;
    logic        [22:0] load_polar;
    logic signed [23:0] load_azimuth;
    logic signed [23:0] kick_polar;
    logic signed [23:0] kick_azimuth;
  } kick_item_t;

  typedef struct packed {
    logic        [22:0] new_polar;
    logic signed [23:0] new_azimuth;
  } angle_pair_t;

  localparam int NumRandom  = 2000;
  localparam int QuietTail  = 150;
  localparam int DrainWait  = 250;
  localparam int Steps      = CordicStepsDefault;

  logic clk;
  logic rst;

  sdr_stream_if #(.payload_t(kick_item_t))  in_if ();
  sdr_stream_if #(.payload_t(angle_pair_t)) out_if ();

  scatter_direction_rotate_unit u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .out (out_if)
  );

  kick_item_t  pending_items[$];
  angle_pair_t expected_angles[$];
  logic [63:0] atan_turns[TableLen];
  logic [22:0] dir_polar;
  logic [23:0] dir_azimuth;
  int          mismatches;
  int          accepted;
  int          total_items;
  int          send_gap;
  int          recv_gap;
  bit          quiet;

  // Arctangent of 2^-i in turn units from the series, scaled by 1/pi.
  task automatic build_atan_turns();
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] prod;
    atan_turns[0] = 64'h1 << 61;
    for (int i = 1; i < TableLen; i++) begin
      acc = '0;
      for (int k = 0; i * (2 * k + 1) <= 63; k++) begin
        term = (64'h1 << (63 - i * (2 * k + 1))) / (2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      prod = {64'h0, acc} * {64'h0, 64'h517CC1B727220A95};
      atan_turns[i] = prod[127:64];
    end
  endtask

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  task automatic cordic_sin_cos(input logic [63:0] ang, output longint c,
                                output longint s);
    logic [1:0] quad;
    bit         flip;
    longint     x, y, dx, dy;
    quad = ang[63:62];
    flip = (quad == 2'd1) || (quad == 2'd2);
    x = InvGainQ30;
    y = 0;
    if (flip) ang = ang + HalfTurn;
    for (int i = 0; i < Steps && i < TableLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (ang[63]) begin
        x = x + dx; y = y - dy; ang = ang + atan_turns[i];
      end else begin
        x = x - dx; y = y + dy; ang = ang - atan_turns[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic cordic_vector(input longint x, input longint y,
                               output logic [63:0] ang, output longint mag);
    longint dx, dy;
    ang = '0;
    if (x == 0 && y == 0) begin
      mag = 0;
      return;
    end
    if (x < 0) begin
      x = -x; y = -y; ang = HalfTurn;
    end
    for (int i = 0; i < Steps && i < TableLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; ang = ang + atan_turns[i];
      end else begin
        x = x - dx; y = y + dy; ang = ang - atan_turns[i];
      end
    end
    mag = x;
  endtask

  function automatic logic [23:0] round_turn(logic [63:0] u);
    logic [63:0] t;
    t = u + (64'h1 << 39);
    return t[63:40];
  endfunction

  // Fold a polar angle into 0 .. pi, saturating at the top of the field.
  function automatic logic [22:0] clamp_polar(logic [63:0] u);
    logic [23:0] r;
    if (u[63]) u = u[62] ? 64'h0 : HalfTurn;
    r = round_turn(u);
    return (r > 24'h7FFFFF) ? 23'h7FFFFF : r[22:0];
  endfunction

  // Advance the direction state by one transaction and return its result.
  task automatic rotate_direction(input kick_item_t item, output angle_pair_t res);
    longint      ct, st, cp, sp, ct0, st0, cp0, sp0, d0, d1, d2;
    longint      x, y, z, mag, rho;
    logic [63:0] az, pol;
    if (item.command == CMD_LOAD) begin
      dir_polar   = item.load_polar;
      dir_azimuth = item.load_azimuth;
    end else begin
      cordic_sin_cos({1'b0, dir_polar, 40'h0}, ct, st);
      cordic_sin_cos({dir_azimuth, 40'h0}, cp, sp);
      cordic_sin_cos({item.kick_polar, 40'h0}, ct0, st0);
      cordic_sin_cos({item.kick_azimuth, 40'h0}, cp0, sp0);
      d0 = qmul(st0, cp0);
      d1 = qmul(st0, sp0);
      d2 = ct0;
      x = -qmul(sp, d0) - qmul(qmul(cp, ct), d1) + qmul(qmul(st, cp), d2);
      y = qmul(cp, d0) - qmul(qmul(sp, ct), d1) + qmul(qmul(st, sp), d2);
      z = qmul(st, d1) + qmul(ct, d2);
      cordic_vector(x, y, az, mag);
      rho = qmul(mag, InvGainQ30);
      cordic_vector(z, rho, pol, mag);
      dir_azimuth = round_turn(az);
      dir_polar   = clamp_polar(pol);
    end
    res.new_polar   = dir_polar;
    res.new_azimuth = dir_azimuth;
  endtask

  function automatic kick_item_t make_item(command_t cmd, logic [22:0] lp,
                                           logic [23:0] la, logic [23:0] kp,
                                           logic [23:0] ka);
    kick_item_t it;
    it.command      = cmd;
    it.load_polar   = lp;
    it.load_azimuth = la;
    it.kick_polar   = kp;
    it.kick_azimuth = ka;
    return it;
  endfunction

  // Scattering deflections are mostly small; keep some full-range ones.
  function automatic kick_item_t random_item();
    logic [23:0] kp;
    if ($urandom_range(0, 4) == 0)
      return make_item(CMD_LOAD, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) < 7) begin
      kp = $urandom_range(0, 300000);
      if ($urandom_range(0, 1)) kp = -kp;
    end else begin
      kp = $urandom;
    end
    return make_item(CMD_KICK, $urandom, $urandom, kp, $urandom);
  endfunction

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  initial begin
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
  end

  // Driver: hold the transaction until accepted, then advance or idle.
  always @(posedge clk) begin
    angle_pair_t res;
    if (rst) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        rotate_direction(in_if.payload, res);
        expected_angles.push_back(res);
        accepted <= accepted + 1;
      end
      if (in_if.valid && !in_if.ready) begin
        // hold the offered transaction
      end else if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        in_if.valid <= 1'b0;
        send_gap    <= $urandom_range(1, 18) - 1;
      end else if (pending_items.size() > 0) begin
        in_if.valid   <= 1'b1;
        in_if.payload <= pending_items.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation; stall at random.
  always @(posedge clk) begin
    angle_pair_t want;
    if (rst) begin
      out_if.ready <= 1'b0;
      recv_gap     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_angles.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("unexpected result polar=%h azimuth=%h",
                     out_if.payload.new_polar, out_if.payload.new_azimuth);
        end else begin
          want = expected_angles.pop_front();
          if (out_if.payload.new_polar !== want.new_polar ||
              out_if.payload.new_azimuth !== want.new_azimuth) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected polar=%h azimuth=%h got polar=%h azimuth=%h",
                       want.new_polar, want.new_azimuth,
                       out_if.payload.new_polar, out_if.payload.new_azimuth);
          end
        end
      end
      if (recv_gap > 0) begin
        out_if.ready <= 1'b0;
        recv_gap     <= recv_gap - 1;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        out_if.ready <= 1'b0;
        recv_gap     <= $urandom_range(1, 18) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    mismatches = 0;
    accepted   = 0;
    quiet      = 1'b0;
    build_atan_turns();
    dir_polar   = '0;
    dir_azimuth = '0;
    // Kick straight from the reset direction, then load field extremes.
    pending_items.push_back(make_item(CMD_KICK, '0, '0, '0, '0));
    pending_items.push_back(make_item(CMD_LOAD, 23'h7FFFFF, 24'h7FFFFF, '0, '0));
    pending_items.push_back(make_item(CMD_LOAD, '0, 24'h800000, 24'hFFFFFF, 24'hFFFFFF));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, '0, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'h7FFFFF, 24'h7FFFFF));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'h800000, 24'h800000));
    // Pole: zero transverse vector, then a kick back past pi.
    pending_items.push_back(make_item(CMD_LOAD, '0, '0, '0, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, '0, 24'h123456));
    pending_items.push_back(make_item(CMD_LOAD, 23'h7FFFFF, '0, '0, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'h000010, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'hFFFFF0, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'h800000, '0));
    // Azimuth near pi, wrapping to minus pi.
    pending_items.push_back(make_item(CMD_LOAD, 23'h400000, 24'h7FFFFF, '0, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, '0, '0));
    pending_items.push_back(make_item(CMD_LOAD, 23'h400000, 24'h800000, '0, '0));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'h400000, 24'h400000));
    pending_items.push_back(make_item(CMD_KICK, '0, '0, 24'hC00000, 24'hC00000));
    for (int n = 0; n < NumRandom; n++) pending_items.push_back(random_item());
    total_items = pending_items.size();

    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    wait (accepted >= total_items - QuietTail);
    quiet = 1'b1;
    wait (pending_items.size() == 0 && accepted == total_items &&
          expected_angles.size() == 0);
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/sdr_pkg.sv
src/sdr_stream_if.sv
src/sdr_ctrl.sv
src/sdr_datapath.sv
src/scatter_direction_rotate_unit.sv
dv/scatter_direction_rotate_unit_test.sv
